// ===== hw/rtl/hpj_pkg.sv =====
// ============================================================================
// Heat plate relaxation package
// Shared widths, codes, reset values and payload types of the heat plate
// Jacobi relaxation block.
// ============================================================================
package hpj_pkg;

    // Field widths.
    localparam int TEMP_W    = 24;
    localparam int ITER_W    = 20;
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    // Default grid size.
    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    // Register reset values: epsilon is about 0.1 in Q8.16.
    localparam logic [TEMP_W-1:0] EPS_RESET  = 24'd6554;
    localparam logic [ITER_W-1:0] ITER_RESET = 20'hFFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Input item.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [TEMP_W-1:0]  temperature;
        logic               locked;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [TEMP_W-1:0] cell_value;
        logic              cell_locked;
        logic [ITER_W-1:0] sweep_count;
        logic              converged;
    } t_out;

    // Operations of the shared stencil unit.
    typedef enum logic [1:0] {
        ALU_HOLD   = 2'd0,
        ALU_CENTER = 2'd1,
        ALU_FIRST  = 2'd2,
        ALU_ADD    = 2'd3
    } t_alu_op;

    // Stencil unit results for the cell just gathered.
    typedef struct packed {
        logic [TEMP_W-1:0] new_temp;
        logic              over_tol;
    } t_alu_res;

    // Memory port controls from the sequencer.
    typedef struct packed {
        logic we_a;
        logic we_b;
        logic we_lock;
        logic lock_val;
        logic rd_b;
    } t_mem_ctl;

endpackage

// ===== hw/rtl/hpj_ram.sv =====
// ============================================================================
// Generic RAM
// Simple dual-port memory: one write port and one read port with registered
// read data.
// ============================================================================
module hpj_ram
    import hpj_pkg::*;
#(
    parameter int WIDTH = TEMP_W,
    parameter int DEPTH = GRID_ROWS_DEF * GRID_COLS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hpj_alu.sv =====
// ============================================================================
// Heat plate stencil unit
// Gathers the center and the four neighbors of one cell, one word a cycle,
// and forms the relaxed value and the out-of-tolerance flag.
// ============================================================================
module hpj_alu
    import hpj_pkg::*;
(
    input  logic              i_clk,
    input  t_alu_op           i_op,
    input  logic [TEMP_W-1:0] i_rd_data,
    input  logic [TEMP_W-1:0] i_epsilon,
    output t_alu_res          o_res
);

    localparam int ACC_W = TEMP_W + 2;
    localparam int SUM_W = TEMP_W + 3;

    logic [TEMP_W-1:0] r_center;
    logic [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]  w_total;
    logic [TEMP_W-1:0] w_mean;
    logic [TEMP_W-1:0] w_diff;

    // Shared accumulator: one read word is taken in each cycle that the op is not ALU_HOLD.
    always_ff @(posedge i_clk) begin
        case (i_op)
            ALU_CENTER: r_center <= i_rd_data;
            ALU_FIRST:  r_acc    <= ACC_W'(i_rd_data);
            ALU_ADD:    r_acc    <= r_acc + ACC_W'(i_rd_data);
            default: begin
            end
        endcase
    end

    // Relaxed value is (neighbor sum + 4 * center) / 8, truncated.
    assign w_total = SUM_W'(r_acc) + SUM_W'({r_center, 2'b00});

    // Neighbor mean and its distance from the center.
    assign w_mean = r_acc[ACC_W-1:2];
    assign w_diff = (r_center > w_mean) ? (r_center - w_mean) : (w_mean - r_center);

    assign o_res.new_temp = w_total[SUM_W-1:3];
    assign o_res.over_tol = (w_diff > i_epsilon);

endmodule

// ===== hw/rtl/hpj_ctrl.sv =====
// ============================================================================
// Heat plate sequencer
// Clears the locked map after reset, handles load and read items, and steps
// the stencil unit through the sweep and check passes of a run.
// ============================================================================
module hpj_ctrl
    import hpj_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    localparam int CELLS    = GRID_ROWS * GRID_COLS,
    localparam int AW       = $clog2(CELLS),
    localparam int RW       = $clog2(GRID_ROWS),
    localparam int CW       = $clog2(GRID_COLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,
    input  logic [ITER_W-1:0] i_max_iter,
    input  logic [TEMP_W-1:0] i_plate_data,
    input  logic              i_lock_data,
    input  t_alu_res          i_alu,
    output t_alu_op           o_alu_op,
    output t_mem_ctl          o_mem,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr,
    output logic [TEMP_W-1:0] o_wdata,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_out              o_res
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_RUN    = 7'b0010000,
        S_CELL   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    // Steps of one cell visit.
    localparam logic [2:0] STEP_ISSUE  = 3'd0;
    localparam logic [2:0] STEP_CENTER = 3'd1;
    localparam logic [2:0] STEP_NORTH  = 3'd2;
    localparam logic [2:0] STEP_SOUTH  = 3'd3;
    localparam logic [2:0] STEP_WEST   = 3'd4;
    localparam logic [2:0] STEP_EAST   = 3'd5;
    localparam logic [2:0] STEP_FINAL  = 3'd6;

    t_state            r_state, n_state;
    logic [2:0]        r_step, n_step;
    logic [RW-1:0]     r_r, n_r;
    logic [CW-1:0]     r_c, n_c;
    logic [AW-1:0]     r_k, n_k;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_inside, n_inside;
    logic              r_edge, n_edge;
    logic [TEMP_W-1:0] r_temp, n_temp;
    logic              r_lock, n_lock;
    logic              r_cur_b, n_cur_b;
    logic              r_check, n_check;
    logic [ITER_W-1:0] r_count, n_count;
    logic              r_conv, n_conv;

    logic              w_in_inside;
    logic              w_in_edge;
    logic [AW-1:0]     w_in_k;
    logic [ITER_W-1:0] w_limit;
    logic              w_last_cell;
    logic              w_cell_done;

    // Decode of the incoming cell address.
    assign w_in_inside = (32'(i_in.row) < GRID_ROWS) && (32'(i_in.col) < GRID_COLS);
    assign w_in_edge   = (i_in.row == '0) || (i_in.col == '0)
                      || (32'(i_in.row) == GRID_ROWS - 1)
                      || (32'(i_in.col) == GRID_COLS - 1);
    assign w_in_k      = AW'(AW'(i_in.row) * AW'(GRID_COLS) + AW'(i_in.col));

    // A sweep limit of zero acts as one.
    assign w_limit = (i_max_iter == '0) ? ITER_W'(1) : i_max_iter;

    assign w_last_cell = (r_r == RW'(GRID_ROWS - 2)) && (r_c == CW'(GRID_COLS - 2));

    assign o_in_ready = (r_state == S_IDLE);
    assign o_waddr    = r_k;
    assign o_wdata    = (r_state == S_CELL) ? i_alu.new_temp : r_temp;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_r         = r_r;
        n_c         = r_c;
        n_k         = r_k;
        n_op        = r_op;
        n_inside    = r_inside;
        n_edge      = r_edge;
        n_temp      = r_temp;
        n_lock      = r_lock;
        n_cur_b     = r_cur_b;
        n_check     = r_check;
        n_count     = r_count;
        n_conv      = r_conv;
        o_alu_op    = ALU_HOLD;
        o_mem       = '0;
        o_mem.rd_b  = r_cur_b;
        o_raddr     = r_k;
        o_res_valid = 1'b0;
        w_cell_done = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_mem.we_lock = 1'b1;
                if (r_k == AW'(CELLS - 1)) begin
                    n_k     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in.op;
                    n_inside = w_in_inside;
                    n_edge   = w_in_edge;
                    n_k      = w_in_k;
                    n_temp   = i_in.temperature;
                    n_lock   = i_in.locked;
                    n_count  = '0;
                    n_check  = 1'b0;
                    n_conv   = 1'b0;
                    case (i_in.op)
                        OP_LOAD: n_state = S_LOAD;
                        OP_RUN:  n_state = S_RUN;
                        OP_READ: n_state = S_READ;
                        default: n_state = S_RESULT;
                    endcase
                end
            end

            S_LOAD: begin
                // A load lands in both buffers.
                if (r_inside) begin
                    o_mem.we_a     = 1'b1;
                    o_mem.we_b     = 1'b1;
                    o_mem.we_lock  = 1'b1;
                    o_mem.lock_val = r_lock;
                end
                n_state = S_RESULT;
            end

            S_READ: begin
                n_state = S_RESULT;
            end

            S_RUN: begin
                // Start a pass at the first interior cell.
                n_r     = RW'(1);
                n_c     = CW'(1);
                n_k     = AW'(GRID_COLS + 1);
                n_step  = STEP_ISSUE;
                n_state = S_CELL;
            end

            S_CELL: begin
                case (r_step)
                    STEP_ISSUE: begin
                        n_step = STEP_CENTER;
                    end
                    STEP_CENTER: begin
                        if (i_lock_data) begin
                            w_cell_done = 1'b1;
                        end else begin
                            o_alu_op = ALU_CENTER;
                            o_raddr  = r_k - AW'(GRID_COLS);
                            n_step   = STEP_NORTH;
                        end
                    end
                    STEP_NORTH: begin
                        o_alu_op = ALU_FIRST;
                        o_raddr  = r_k + AW'(GRID_COLS);
                        n_step   = STEP_SOUTH;
                    end
                    STEP_SOUTH: begin
                        o_alu_op = ALU_ADD;
                        o_raddr  = r_k - AW'(1);
                        n_step   = STEP_WEST;
                    end
                    STEP_WEST: begin
                        o_alu_op = ALU_ADD;
                        o_raddr  = r_k + AW'(1);
                        n_step   = STEP_EAST;
                    end
                    STEP_EAST: begin
                        o_alu_op = ALU_ADD;
                        n_step   = STEP_FINAL;
                    end
                    STEP_FINAL: begin
                        if (!r_check) begin
                            // Sweep: write the other buffer.
                            o_mem.we_a  = r_cur_b;
                            o_mem.we_b  = ~r_cur_b;
                            w_cell_done = 1'b1;
                        end else if (i_alu.over_tol) begin
                            // Not steady: the check pass ends here.
                            n_step = STEP_ISSUE;
                            if (r_count >= w_limit) begin
                                n_conv  = 1'b0;
                                n_state = S_RESULT;
                            end else begin
                                n_check = 1'b0;
                                n_state = S_RUN;
                            end
                        end else begin
                            w_cell_done = 1'b1;
                        end
                    end
                    default: begin
                        n_step = STEP_ISSUE;
                    end
                endcase

                // Move on to the next interior cell or close the pass.
                if (w_cell_done) begin
                    n_step = STEP_ISSUE;
                    if (w_last_cell) begin
                        if (!r_check) begin
                            n_cur_b = ~r_cur_b;
                            n_count = r_count + ITER_W'(1);
                            n_check = 1'b1;
                            n_state = S_RUN;
                        end else begin
                            n_conv  = 1'b1;
                            n_state = S_RESULT;
                        end
                    end else if (r_c == CW'(GRID_COLS - 2)) begin
                        n_r = r_r + RW'(1);
                        n_c = CW'(1);
                        n_k = r_k + AW'(3);
                    end else begin
                        n_c = r_c + CW'(1);
                        n_k = r_k + AW'(1);
                    end
                end
            end

            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result fields: only the fields of the item's own op are nonzero.
    always_comb begin
        o_res = '0;
        if (r_op == OP_READ && r_inside) begin
            o_res.cell_value  = i_plate_data;
            o_res.cell_locked = i_lock_data | r_edge;
        end
        if (r_op == OP_RUN) begin
            o_res.sweep_count = r_count;
            o_res.converged   = r_conv;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= STEP_ISSUE;
            r_r     <= RW'(1);
            r_c     <= CW'(1);
            r_k     <= '0;
            r_op    <= OP_LOAD;
            r_cur_b <= 1'b0;
            r_check <= 1'b0;
            r_count <= '0;
            r_conv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
            r_op    <= n_op;
            r_cur_b <= n_cur_b;
            r_check <= n_check;
            r_count <= n_count;
            r_conv  <= n_conv;
        end
    end

    // Request payload registers.
    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
        r_edge   <= n_edge;
        r_temp   <= n_temp;
        r_lock   <= n_lock;
    end

`ifndef SYNTHESIS
    // The cell counters stay inside the interior of the grid.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_r != '0 && r_c != '0
            && r_r <= RW'(GRID_ROWS - 2) && r_c <= CW'(GRID_COLS - 2)))
        else $error("cell counters left the interior");

    // The linear address tracks row and column.
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_k == AW'(AW'(r_r) * AW'(GRID_COLS) + AW'(r_c))))
        else $error("cell address out of step with row and column");

    // Sweep writes go only to the buffer that is not being read.
    a_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && (o_mem.we_a || o_mem.we_b))
            |-> (!r_check && (o_mem.we_a == r_cur_b) && (o_mem.we_b == !r_cur_b)))
        else $error("sweep write to the source buffer");

    // A sweep pass is only started below the sweep limit.
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && !r_check) |-> (r_count < w_limit))
        else $error("sweep beyond the limit");

    // A locked cell is skipped right after its flag is read.
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && r_step == STEP_CENTER && i_lock_data)
            |=> (r_step == STEP_ISSUE))
        else $error("locked cell was not skipped");
`endif

endmodule

// ===== hw/rtl/heat_plate_jacobi_relaxation.sv =====
// ============================================================================
// Heat plate Jacobi relaxation
// Loads a grid of Q8.16 temperatures with locked flags, relaxes it with a
// five-point stencil until steady or at a sweep limit, and reads cells back.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready / i_in) takes load, run and read
//   items; each item yields exactly one result on the output channel
//   (o_out_valid / i_out_ready / o_out).
// - A load or read item goes through its load or read state to the result
//   state, and the next item is taken only after that result has moved on.
// - Each sweep of a run has a setup state, then visits every interior cell,
//   a locked one in the issue and center steps only, an unlocked one in all
//   steps from issue to final; a check pass of the same steps follows and
//   stops at the first cell out of tolerance. The single shared stencil unit
//   and the one read port of each memory make the steps run one at a time.
// - After reset the locked map is cleared one entry a cycle over all of its
//   entries; no item is taken meanwhile, configuration writes are.
// - A finished result sits in the output register while the receiver stalls;
//   the block then holds its next result and takes no new item.
// ============================================================================
module heat_plate_jacobi_relaxation
    import hpj_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);

    logic [TEMP_W-1:0] r_epsilon;
    logic [ITER_W-1:0] r_max_iter;
    logic              r_out_valid;
    t_out              r_out;
    logic              r_rd_b_q;

    t_alu_op           w_alu_op;
    t_alu_res          w_alu;
    t_mem_ctl          w_mem;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [TEMP_W-1:0] w_wdata;
    logic [TEMP_W-1:0] w_data_a;
    logic [TEMP_W-1:0] w_data_b;
    logic [TEMP_W-1:0] w_plate_data;
    logic              w_lock_data;
    logic              w_res_valid;
    logic              w_res_ready;
    t_out              w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon  <= EPS_RESET;
            r_max_iter <= ITER_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_EPSILON) begin
                r_epsilon <= i_cfg_data[TEMP_W-1:0];
            end else if (i_cfg_idx == CFG_MAX_ITER) begin
                r_max_iter <= i_cfg_data[ITER_W-1:0];
            end
        end
    end

    // Buffer select is registered so that it lines up with the registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_b_q <= w_mem.rd_b;
    end

    assign w_plate_data = r_rd_b_q ? w_data_b : w_data_a;

    hpj_ctrl #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_max_iter   (r_max_iter),
        .i_plate_data (w_plate_data),
        .i_lock_data  (w_lock_data),
        .i_alu        (w_alu),
        .o_alu_op     (w_alu_op),
        .o_mem        (w_mem),
        .o_waddr      (w_waddr),
        .o_raddr      (w_raddr),
        .o_wdata      (w_wdata),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    hpj_alu u_alu (
        .i_clk     (i_clk),
        .i_op      (w_alu_op),
        .i_rd_data (w_plate_data),
        .i_epsilon (r_epsilon),
        .o_res     (w_alu)
    );

    // Ping-pong temperature buffers.
    hpj_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (CELLS)
    ) u_plate_a (
        .i_clk   (i_clk),
        .i_we    (w_mem.we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_data_a)
    );

    hpj_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (CELLS)
    ) u_plate_b (
        .i_clk   (i_clk),
        .i_we    (w_mem.we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_data_b)
    );

    // Locked flags.
    hpj_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_lock_map (
        .i_clk   (i_clk),
        .i_we    (w_mem.we_lock),
        .i_waddr (w_waddr),
        .i_wdata (w_mem.lock_val),
        .i_raddr (w_raddr),
        .o_rdata (w_lock_data)
    );

    // Output register: a new result moves in when the slot is free or drains.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== tb/heat_plate_jacobi_relaxation_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Heat plate Jacobi relaxation testbench
// Loads the whole plate, walks a short table of directed operations and
// register settings, then sends random load, read, run and unused operations
// under several tolerance and sweep-limit settings. Every result is compared
// with a fixed answer from the table or with a plate model kept in this bench,
// with random idling on both channels and one long hold-off on the result side.
// ============================================================================
module heat_plate_jacobi_relaxation_test;
    import hpj_pkg::*;

    localparam int ROWS  = GRID_ROWS_DEF;
    localparam int COLS  = GRID_COLS_DEF;
    localparam int CELLS = ROWS * COLS;

    // The fourth operation code has no function in the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Uniform starting temperature (20.0) and the unlocked window of the plate.
    localparam logic [TEMP_W-1:0] T_BASE = 24'h140000;
    localparam int WIN_LO = 28;
    localparam int WIN_HI = 35;

    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 140;
    localparam int RUNS_PER_PH  = 4;
    localparam int SETTLE       = 4;
    localparam int DRAIN        = 20;
    localparam int HOLD_AT      = CELLS + 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int PRINT_MAX    = 100;

    // One row of the directed table: either an operation or a register write.
    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_in                  item;
        logic                 typed;
        t_out                 typed_res;
    } t_plan_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in       = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Plate model: both buffers, locked flags, buffer select and registers.
    logic [TEMP_W-1:0] heat [2][CELLS];
    logic              pinned [CELLS];
    logic              cur_plate;
    logic [TEMP_W-1:0] tol_eps;
    logic [ITER_W-1:0] sweep_cap;

    t_out      answers_due [$];
    t_plan_row plan [$];
    int        n_results  = 0;
    int        n_mismatch = 0;
    int        n_cycles   = 0;
    int        runs_left  = 0;
    logic      tx_calm    = 1'b0;

    heat_plate_jacobi_relaxation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // One Jacobi sweep from buffer src into the other buffer.
    function automatic void relax_sweep(logic src);
        int k;
        logic [31:0] acc;
        for (int r = 1; r < ROWS - 1; r++) begin
            for (int c = 1; c < COLS - 1; c++) begin
                k = r * COLS + c;
                if (!pinned[k]) begin
                    acc = heat[src][k - COLS] + heat[src][k + COLS] + heat[src][k - 1]
                        + heat[src][k + 1] + 4 * heat[src][k];
                    heat[src ^ 1'b1][k] = acc[TEMP_W+2:3];
                end
            end
        end
    endfunction

    // True when no unlocked interior cell is off its neighbor mean by more than epsilon.
    function automatic logic plate_steady(logic g);
        int k;
        logic [31:0] mean;
        logic [31:0] diff;
        for (int r = 1; r < ROWS - 1; r++) begin
            for (int c = 1; c < COLS - 1; c++) begin
                k = r * COLS + c;
                if (!pinned[k]) begin
                    mean = (heat[g][k - COLS] + heat[g][k + COLS] + heat[g][k - 1]
                        + heat[g][k + 1]) >> 2;
                    diff = (heat[g][k] > mean) ? heat[g][k] - mean : mean - heat[g][k];
                    if (diff > tol_eps) return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Applies one operation to the plate model and returns the block's answer.
    function automatic t_out plate_answer(t_in it);
        t_out res;
        int   k;
        int   limit;
        int   n;
        logic done;
        res = '0;
        k = int'(it.row) * COLS + int'(it.col);
        case (it.op)
            OP_LOAD: begin
                heat[0][k] = it.temperature;
                heat[1][k] = it.temperature;
                pinned[k]  = it.locked;
            end
            OP_RUN: begin
                limit = (sweep_cap == '0) ? 1 : int'(sweep_cap);
                n = 0;
                do begin
                    relax_sweep(cur_plate);
                    cur_plate = ~cur_plate;
                    n++;
                    done = plate_steady(cur_plate);
                end while (!done && n < limit);
                res.sweep_count = n[ITER_W-1:0];
                res.converged   = done;
            end
            OP_READ: begin
                res.cell_value  = heat[cur_plate][k];
                res.cell_locked = pinned[k] || it.row == '0 || it.col == '0
                    || int'(it.row) == ROWS - 1 || int'(it.col) == COLS - 1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random operation; runs are rationed since each one sweeps the whole plate.
    function automatic t_in random_item();
        t_in it;
        int  roll;
        roll = $urandom_range(0, 99);
        if (roll < 3 && runs_left > 0) begin
            it.op = OP_RUN;
            runs_left--;
        end else if (roll < 6) begin
            it.op = OP_UNUSED;
        end else if (roll < 52) begin
            it.op = OP_LOAD;
        end else begin
            it.op = OP_READ;
        end
        if ($urandom_range(0, 1) == 1) begin
            it.row = COORD_W'($urandom_range(WIN_LO - 2, WIN_HI + 2));
            it.col = COORD_W'($urandom_range(WIN_LO - 2, WIN_HI + 2));
        end else begin
            it.row = COORD_W'($urandom_range(0, ROWS - 1));
            it.col = COORD_W'($urandom_range(0, COLS - 1));
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) it.temperature = '0;
        else if (roll == 1) it.temperature = '1;
        else if (roll < 7) it.temperature =
            TEMP_W'(T_BASE + $urandom_range(0, 24'h1FFFF) - 24'h10000);
        else it.temperature = TEMP_W'($urandom_range(0, 24'hFFFFFF));
        it.locked = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void plan_op(logic [OP_W-1:0] op, int r, int c,
            logic [TEMP_W-1:0] temp, logic lk, logic typed = 1'b0,
            logic [TEMP_W-1:0] cell_val = '0, logic cell_lk = 1'b0,
            int n_sweeps = 0, logic conv = 1'b0);
        t_plan_row row;
        row = '0;
        row.item.op          = op;
        row.item.row         = r[COORD_W-1:0];
        row.item.col         = c[COORD_W-1:0];
        row.item.temperature = temp;
        row.item.locked      = lk;
        row.typed            = typed;
        row.typed_res.cell_value  = cell_val;
        row.typed_res.cell_locked = cell_lk;
        row.typed_res.sweep_count = n_sweeps[ITER_W-1:0];
        row.typed_res.converged   = conv;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_plan_row row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what);
        if (n_mismatch < PRINT_MAX) $display("mismatch: %s", what);
        n_mismatch++;
    endtask

    // Offers one operation after a random gap and books its answer on transfer.
    task automatic send_item(input t_in item, input logic typed, input t_out typed_res);
        int   gap;
        t_out due;
        if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        due = plate_answer(item);
        answers_due.push_back(typed ? typed_res : due);
    endtask

    // Registers change only once every booked answer has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_EPSILON) tol_eps = val[TEMP_W-1:0];
        else if (idx == CFG_MAX_ITER) sweep_cap = val[ITER_W-1:0];
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin : result_side
        int   stall_left;
        logic calm;
        logic held;
        stall_left = 0;
        calm = 1'b0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && n_results >= HOLD_AT) begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
            end
            if ($urandom_range(0, 255) == 0) calm = ~calm;
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Each result transfer is checked against the oldest booked answer.
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results <= n_results + 1;
            if (answers_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing due", n_results));
            end else begin
                want = answers_due.pop_front();
                if (o_out.cell_value !== want.cell_value)
                    flag_mismatch($sformatf("result %0d cell_value %h, want %h",
                        n_results, o_out.cell_value, want.cell_value));
                if (o_out.cell_locked !== want.cell_locked)
                    flag_mismatch($sformatf("result %0d cell_locked %b, want %b",
                        n_results, o_out.cell_locked, want.cell_locked));
                if (o_out.sweep_count !== want.sweep_count)
                    flag_mismatch($sformatf("result %0d sweep_count %0d, want %0d",
                        n_results, o_out.sweep_count, want.sweep_count));
                if (o_out.converged !== want.converged)
                    flag_mismatch($sformatf("result %0d converged %b, want %b",
                        n_results, o_out.converged, want.converged));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_in it;
        logic interior;
        logic [CFG_W-1:0] eps_val;
        logic [CFG_W-1:0] cap_val;

        foreach (pinned[k]) pinned[k] = 1'b0;
        cur_plate = 1'b0;
        tol_eps   = EPS_RESET;
        sweep_cap = ITER_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole plate: all interior cells locked but a small window.
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                interior = r > 0 && c > 0 && r < ROWS - 1 && c < COLS - 1;
                it.op          = OP_LOAD;
                it.row         = r[COORD_W-1:0];
                it.col         = c[COORD_W-1:0];
                it.temperature = T_BASE;
                it.locked      = interior && !(r >= WIN_LO && r <= WIN_HI
                    && c >= WIN_LO && c <= WIN_HI);
                send_item(it, 1'b0, '0);
            end
        end

        // Directed table: unused op, edges and corners, extreme temperatures,
        // zero sweep limit, zero tolerance, and steadiness on the last sweep.
        plan_op(OP_UNUSED, 63, 63, 24'hFFFFFF, 1'b1, 1'b1);
        plan_op(OP_READ, 0, 0, '0, 1'b0, 1'b1, T_BASE, 1'b1);
        plan_op(OP_READ, 63, 63, '0, 1'b0, 1'b1, T_BASE, 1'b1);
        plan_op(OP_READ, 32, 32, '0, 1'b0, 1'b1, T_BASE, 1'b0);
        plan_op(OP_READ, 1, 1, '0, 1'b0, 1'b1, T_BASE, 1'b1);
        plan_op(OP_RUN, 0, 0, '0, 1'b0, 1'b1, '0, 1'b0, 1, 1'b1);
        plan_op(OP_READ, 32, 32, '0, 1'b0, 1'b1, T_BASE, 1'b0);
        plan_op(OP_LOAD, 0, 63, 24'hFFFFFF, 1'b0, 1'b1);
        plan_op(OP_READ, 0, 63, '0, 1'b0, 1'b1, 24'hFFFFFF, 1'b1);
        plan_op(OP_LOAD, 63, 0, '0, 1'b1, 1'b1);
        plan_op(OP_READ, 63, 0, '0, 1'b0, 1'b1, '0, 1'b1);
        plan_op(OP_LOAD, 31, 31, 24'hFFFFFF, 1'b0, 1'b1);
        plan_op(OP_LOAD, 32, 32, '0, 1'b0, 1'b1);
        plan_op(OP_LOAD, 33, 33, 24'hFFFFFF, 1'b1, 1'b1);
        plan_reg(CFG_MAX_ITER, '0);
        plan_reg(CFG_EPSILON, '0);
        plan_op(OP_RUN, 0, 0, '0, 1'b0);
        plan_op(OP_READ, 31, 31, '0, 1'b0);
        plan_op(OP_READ, 32, 32, '0, 1'b0);
        plan_reg(CFG_MAX_ITER, 24'd2);
        plan_op(OP_RUN, 0, 0, '0, 1'b0);
        plan_op(OP_READ, 33, 33, '0, 1'b0, 1'b1, 24'hFFFFFF, 1'b1);
        plan_op(OP_LOAD, 62, 62, '0, 1'b0, 1'b1);
        plan_op(OP_READ, 62, 62, '0, 1'b0, 1'b1, '0, 1'b0);
        plan_reg(CFG_EPSILON, 24'hFFFFFF);
        plan_reg(CFG_MAX_ITER, 24'd1);
        plan_op(OP_RUN, 0, 0, '0, 1'b0, 1'b1, '0, 1'b0, 1, 1'b1);
        plan_op(OP_READ, 62, 62, '0, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].typed_res);
            end
        end

        // Random phases, from the widest settings to tight tolerance and few sweeps.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    eps_val = 24'hFFFFFF;
                    cap_val = 24'hFFFFF;
                end
                1: begin
                    eps_val = '0;
                    cap_val = 24'd1;
                end
                2: begin
                    eps_val = '0;
                    cap_val = '0;
                end
                3: begin
                    eps_val = CFG_W'($urandom_range(1000, 20000));
                    cap_val = 24'd3;
                end
                default: begin
                    eps_val = CFG_W'($urandom_range(0, 65535));
                    cap_val = CFG_W'($urandom_range(2, 4));
                end
            endcase
            write_reg(CFG_EPSILON, eps_val);
            write_reg(CFG_MAX_ITER, cap_val);
            runs_left = RUNS_PER_PH;
            repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
